>>> rtl/one_wire_bus_master_unit_defines.svh
// shared assertion macros
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OWBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/owbm_pkg.sv
package owbm_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_NUM   = 8;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_REC     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_REC      = 3'd7;

	// reset values, entry 0 in the lowest slot
	localparam logic [CFG_NUM-1:0][CFG_W-1:0] CFG_RESET = {
		16'd2, 16'd50, 16'd10, 16'd2, 16'd10, 16'd500, 16'd70, 16'd500
	};

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_RESET = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// stream layouts
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam int OUT_DRIVE    = 0;
	localparam int OUT_BUSY     = 1;
	localparam int OUT_DONE     = 2;
	localparam int OUT_PRESENCE = 3;
	localparam int OUT_RDATA_LO = 4;
	localparam int OUT_REJECTED = 12;

	// classified tick, as queued between front and back
	typedef struct packed {
		logic       start_rst;
		logic       start_wr;
		logic       start_rd;
		logic [7:0] wdata;
		logic       level;
	} owbm_item_t;

endpackage

>>> rtl/owbm_front.sv
module owbm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [owbm_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               q_push,
	output owbm_pkg::owbm_item_t               q_item,
	input  logic                               q_ready
);

	logic                  valid_s1;
	owbm_pkg::owbm_item_t  item_s1;
	owbm_pkg::owbm_item_t  item_dec;
	logic [1:0]            req;

	assign req = s_tdata[1:0];

	always_comb begin
		item_dec.start_rst = 1'b0;
		item_dec.start_wr  = 1'b0;
		item_dec.start_rd  = 1'b0;
		item_dec.wdata     = s_tdata[9:2];
		item_dec.level     = s_tdata[10];
		unique case (req)
			owbm_pkg::REQ_TICK:  ;
			owbm_pkg::REQ_RESET: item_dec.start_rst = 1'b1;
			owbm_pkg::REQ_WRITE: item_dec.start_wr  = 1'b1;
			owbm_pkg::REQ_READ:  item_dec.start_rd  = 1'b1;
			default:             ;
		endcase
	end

	assign s_tready = !valid_s1 || q_ready;
	assign q_push   = valid_s1 && q_ready;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_dec;
		end
	end

endmodule

>>> rtl/owbm_queue.sv
module owbm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  owbm_pkg::owbm_item_t  push_item,
	output logic                  push_ready,
	output logic                  head_valid,
	output owbm_pkg::owbm_item_t  head_item,
	input  logic                  pop
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	owbm_pkg::owbm_item_t  slot_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/owbm_back.sv
`include "one_wire_bus_master_unit_defines.svh"

module owbm_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [owbm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                q_valid,
	input  owbm_pkg::owbm_item_t                q_item,
	output logic                                q_pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [owbm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int LW = (COUNT_WIDTH > owbm_pkg::CFG_W) ? COUNT_WIDTH : owbm_pkg::CFG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_REC  = 4'd3;
	localparam logic [3:0] PH_W_LOW    = 4'd4;
	localparam logic [3:0] PH_W_HOLD   = 4'd5;
	localparam logic [3:0] PH_W_REC    = 4'd6;
	localparam logic [3:0] PH_R_LOW    = 4'd7;
	localparam logic [3:0] PH_R_WAIT   = 4'd8;
	localparam logic [3:0] PH_R_HOLD   = 4'd9;
	localparam logic [3:0] PH_R_REC    = 4'd10;

	logic [owbm_pkg::CFG_W-1:0]  cfg_q [owbm_pkg::CFG_NUM];
	logic [owbm_pkg::CFG_W-1:0]  rwait_q;

	logic [3:0]              phase_q, phase_n;
	logic [COUNT_WIDTH-1:0]  tick_q, tick_n, tick_inc;
	logic [2:0]              bit_q, bit_n;
	logic [7:0]              shift_q, shift_n;
	logic                    pres_q, pres_n;
	logic [7:0]              rbyte_q, rbyte_n;

	logic [owbm_pkg::CFG_W-1:0]  len_raw;
	logic [LW-1:0]               len_ext;
	logic                        phase_end;
	logic                        any_start;
	logic                        done, rejected, drive;

	logic                                 m_tvalid_q;
	logic [owbm_pkg::OUT_TDATA_W-1:0]     m_tdata_q;
	logic [owbm_pkg::OUT_TDATA_W-1:0]     res_word;

	// config registers, plus the released wait before the read sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < owbm_pkg::CFG_NUM; i++) begin
				cfg_q[i] <= owbm_pkg::CFG_RESET[i];
			end
			rwait_q <= owbm_pkg::CFG_RESET[owbm_pkg::REG_READ_SAMPLE]
				- owbm_pkg::CFG_RESET[owbm_pkg::REG_READ_LOW];
		end else begin
			if (cfg_we) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			rwait_q <= (cfg_q[owbm_pkg::REG_READ_SAMPLE] > cfg_q[owbm_pkg::REG_READ_LOW])
				? cfg_q[owbm_pkg::REG_READ_SAMPLE] - cfg_q[owbm_pkg::REG_READ_LOW]
				: owbm_pkg::CFG_W'(1);
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_RST_LOW:            len_raw = cfg_q[owbm_pkg::REG_RESET_LOW];
			PH_RST_WAIT:           len_raw = cfg_q[owbm_pkg::REG_PRESENCE_WAIT];
			PH_RST_REC:            len_raw = cfg_q[owbm_pkg::REG_RESET_REC];
			PH_W_LOW:              len_raw = cfg_q[owbm_pkg::REG_WRITE_LOW];
			PH_R_LOW:              len_raw = cfg_q[owbm_pkg::REG_READ_LOW];
			PH_R_WAIT:             len_raw = rwait_q;
			PH_W_HOLD, PH_R_HOLD:  len_raw = cfg_q[owbm_pkg::REG_SLOT_HOLD];
			default:               len_raw = cfg_q[owbm_pkg::REG_SLOT_REC];
		endcase
	end

	// zero register means one tick; count saturates at its max
	assign len_ext   = (len_raw == '0) ? LW'(1) : LW'(len_raw);
	assign tick_inc  = (tick_q == CNT_MAX) ? tick_q : tick_q + 1'b1;
	assign phase_end = (LW'(tick_inc) >= len_ext) || (tick_inc == CNT_MAX);
	assign any_start = q_item.start_rst || q_item.start_wr || q_item.start_rd;

	always_comb begin
		phase_n  = phase_q;
		tick_n   = tick_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		pres_n   = pres_q;
		rbyte_n  = rbyte_q;
		done     = 1'b0;
		rejected = 1'b0;
		if (phase_q == PH_IDLE) begin
			priority if (q_item.start_rst) begin
				phase_n = PH_RST_LOW;
			end else if (q_item.start_wr) begin
				phase_n = PH_W_LOW;
				shift_n = q_item.wdata;
				bit_n   = '0;
			end else if (q_item.start_rd) begin
				phase_n = PH_R_LOW;
				shift_n = '0;
				bit_n   = '0;
			end
		end else begin
			rejected = any_start;
			tick_n   = tick_inc;
			if (phase_end) begin
				tick_n = '0;
				unique case (phase_q)
					PH_RST_LOW:  phase_n = PH_RST_WAIT;
					PH_RST_WAIT: begin
						pres_n  = !q_item.level;
						phase_n = PH_RST_REC;
					end
					PH_RST_REC: begin
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
					PH_W_LOW:    phase_n = PH_W_HOLD;
					PH_W_HOLD:   phase_n = PH_W_REC;
					PH_R_LOW:    phase_n = PH_R_WAIT;
					PH_R_WAIT: begin
						if (q_item.level) begin
							shift_n[bit_q] = 1'b1;
						end
						phase_n = PH_R_HOLD;
					end
					PH_R_HOLD:   phase_n = PH_R_REC;
					PH_W_REC, PH_R_REC: begin
						if (bit_q == 3'd7) begin
							if (phase_q == PH_R_REC) begin
								rbyte_n = shift_q;
							end
							bit_n   = '0;
							phase_n = PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_n   = bit_q + 1'b1;
							phase_n = (phase_q == PH_R_REC) ? PH_R_LOW : PH_W_LOW;
						end
					end
					default:     phase_n = PH_IDLE;
				endcase
			end
		end
	end

	// drive level for the next tick, from the updated state
	always_comb begin
		if (phase_n == PH_RST_LOW || phase_n == PH_W_LOW || phase_n == PH_R_LOW) begin
			drive = 1'b1;
		end else if (phase_n == PH_W_HOLD) begin
			drive = !shift_n[bit_n];
		end else begin
			drive = 1'b0;
		end
	end

	always_comb begin
		res_word = '0;
		res_word[owbm_pkg::OUT_DRIVE]         = drive;
		res_word[owbm_pkg::OUT_BUSY]          = (phase_n != PH_IDLE);
		res_word[owbm_pkg::OUT_DONE]          = done;
		res_word[owbm_pkg::OUT_PRESENCE]      = pres_n;
		res_word[owbm_pkg::OUT_RDATA_LO +: 8] = rbyte_n;
		res_word[owbm_pkg::OUT_REJECTED]      = rejected;
	end

	assign q_pop = q_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			pres_q     <= 1'b0;
			rbyte_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q <= phase_n;
				tick_q  <= tick_n;
				bit_q   <= bit_n;
				shift_q <= shift_n;
				pres_q  <= pres_n;
				rbyte_q <= rbyte_n;
			end
			if (q_pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			m_tdata_q <= res_word;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`OWBM_ASSERT_NOW(a_idle_clean, phase_q == PH_IDLE, tick_q == '0 && bit_q == '0,
		"idle with live counters")
	`OWBM_ASSERT_NEXT(a_start_leaves_idle, q_pop && phase_q == PH_IDLE && any_start,
		phase_q != PH_IDLE && m_tvalid && m_tdata[owbm_pkg::OUT_BUSY],
		"start did not begin a command")
	`OWBM_ASSERT_NEXT(a_busy_reject, q_pop && phase_q != PH_IDLE && any_start,
		m_tvalid && m_tdata[owbm_pkg::OUT_REJECTED], "start while busy not flagged")
	`OWBM_ASSERT_NOW(a_done_idle, q_pop && done, phase_n == PH_IDLE,
		"done without returning to idle")

endmodule

>>> rtl/one_wire_bus_master_unit.sv
// 1-Wire bus master, one beat per bus time tick. Each input beat carries the
// request, the byte to send and the sampled bus level; each yields exactly one
// result beat with drive_low for the next tick, status, presence and the last
// byte read. A new beat is taken every clock unless the output stalls, and goes
// through the decode register, two-entry queue and output register; the back-end
// phase sequencer, updating its counters once per beat, sets that rate. The user
// must write timing registers on the cfg port only while no beat is in flight;
// the block does not enforce it. A zero value counts as one tick.
module one_wire_bus_master_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [owbm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// req_type[1:0], write_data[9:2], bus_level[10], zero fill
	input  logic [owbm_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// drive_low[0], busy_res[1], done_res[2], presence[3], read_data[11:4],
	// rejected[12], zero fill
	output logic [owbm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	logic                  push, push_ready, head_valid, pop;
	owbm_pkg::owbm_item_t  push_item, head_item;

	owbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_push   (push),
		.q_item   (push_item),
		.q_ready  (push_ready)
	);

	owbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	owbm_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (head_valid),
		.q_item    (head_item),
		.q_pop     (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> tb/one_wire_bus_master_unit_tb.sv
`timescale 1ns / 100ps

module one_wire_bus_master_unit_tb;

	localparam int IDLE_LIMIT    = 1000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_TICKS   = 100;

	// bus level choice for the ticks of a command
	localparam int LVL_RANDOM = 0;
	localparam int LVL_LOW    = 1;
	localparam int LVL_HIGH   = 2;

	typedef enum logic [3:0] {
		BUS_IDLE, RST_LOW, RST_WAIT, RST_REC, WR_LOW, WR_HOLD, WR_REC,
		RD_LOW, RD_WAIT, RD_HOLD, RD_REC
	} bus_phase_t;

	typedef struct packed {
		logic [1:0] req;
		logic [7:0] wdata;
		logic       level;
	} bus_tick_t;

	typedef struct packed {
		logic       drive;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] rdata;
		logic       rejected;
	} bus_status_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_we    = 1'b0;
	logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [owbm_pkg::CFG_W-1:0]       cfg_data  = '0;
	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	// req_type[1:0], write_data[9:2], bus_level[10], zero fill
	logic [owbm_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	// drive_low[0], busy_res[1], done_res[2], presence[3], read_data[11:4],
	// rejected[12], zero fill
	logic [owbm_pkg::OUT_TDATA_W-1:0] m_tdata;

	one_wire_bus_master_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// timing registers and sequencer state as the bus master should hold them
	logic [owbm_pkg::CFG_W-1:0] timing [owbm_pkg::CFG_NUM] = '{16'd500, 16'd70, 16'd500,
		16'd10, 16'd2, 16'd10, 16'd50, 16'd2};
	bus_phase_t  phase_now     = BUS_IDLE;
	logic [15:0] phase_count   = '0;
	logic [2:0]  bit_pos       = '0;
	logic [7:0]  shift_reg     = '0;
	logic        presence_seen = 1'b0;
	logic [7:0]  byte_read     = '0;

	bus_tick_t   tick_queue[$];
	bus_status_t status_queue[$];
	bus_tick_t   held_tick   = '0;
	bit          holding     = 1'b0;
	int          gap_left    = 0;
	int          stall_left  = 0;
	bit          steady_in   = 1'b0;
	bit          steady_out  = 1'b0;
	int          queued      = 0;
	int          errors      = 0;
	int          idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] phase_ticks(bus_phase_t ph);
		logic [15:0] n;
		case (ph)
			RST_LOW:  n = timing[owbm_pkg::REG_RESET_LOW];
			RST_WAIT: n = timing[owbm_pkg::REG_PRESENCE_WAIT];
			RST_REC:  n = timing[owbm_pkg::REG_RESET_REC];
			WR_LOW:   n = timing[owbm_pkg::REG_WRITE_LOW];
			RD_LOW:   n = timing[owbm_pkg::REG_READ_LOW];
			// released wait up to the read sample, at least one tick
			RD_WAIT:  n = (timing[owbm_pkg::REG_READ_SAMPLE] > timing[owbm_pkg::REG_READ_LOW])
				? timing[owbm_pkg::REG_READ_SAMPLE] - timing[owbm_pkg::REG_READ_LOW]
				: 16'd1;
			WR_HOLD, RD_HOLD: n = timing[owbm_pkg::REG_SLOT_HOLD];
			default:  n = timing[owbm_pkg::REG_SLOT_REC];
		endcase
		return (n == 16'd0) ? 16'd1 : n;
	endfunction

	// ticks after the start tick until the command reports done
	function automatic int command_ticks(logic [1:0] req);
		case (req)
			owbm_pkg::REQ_RESET: return int'(phase_ticks(RST_LOW)) +
				int'(phase_ticks(RST_WAIT)) + int'(phase_ticks(RST_REC));
			owbm_pkg::REQ_WRITE: return 8 * (int'(phase_ticks(WR_LOW)) +
				int'(phase_ticks(WR_HOLD)) + int'(phase_ticks(WR_REC)));
			owbm_pkg::REQ_READ:  return 8 * (int'(phase_ticks(RD_LOW)) +
				int'(phase_ticks(RD_WAIT)) + int'(phase_ticks(RD_HOLD)) +
				int'(phase_ticks(RD_REC)));
			default:             return 0;
		endcase
	endfunction

	task automatic step_bus(input bus_tick_t t);
		bus_status_t r;
		logic        reading;
		r = '0;
		reading = 1'b0;
		if (phase_now == BUS_IDLE) begin
			case (t.req)
				owbm_pkg::REQ_RESET: phase_now = RST_LOW;
				owbm_pkg::REQ_WRITE: begin
					shift_reg = t.wdata;
					bit_pos = '0;
					phase_now = WR_LOW;
				end
				owbm_pkg::REQ_READ: begin
					shift_reg = '0;
					bit_pos = '0;
					phase_now = RD_LOW;
				end
				default: ;
			endcase
			phase_count = '0;
		end else begin
			r.rejected = (t.req != owbm_pkg::REQ_TICK);
			if (phase_count != 16'hFFFF)
				phase_count++;
			if (phase_count >= phase_ticks(phase_now) || phase_count == 16'hFFFF) begin
				phase_count = '0;
				case (phase_now)
					RST_LOW:  phase_now = RST_WAIT;
					RST_WAIT: begin
						presence_seen = ~t.level;
						phase_now = RST_REC;
					end
					RST_REC: begin
						phase_now = BUS_IDLE;
						r.done = 1'b1;
					end
					WR_LOW:   phase_now = WR_HOLD;
					WR_HOLD:  phase_now = WR_REC;
					RD_LOW:   phase_now = RD_WAIT;
					RD_WAIT: begin
						if (t.level)
							shift_reg[bit_pos] = 1'b1;
						phase_now = RD_HOLD;
					end
					RD_HOLD:  phase_now = RD_REC;
					WR_REC, RD_REC: begin
						reading = (phase_now == RD_REC);
						if (bit_pos == 3'd7) begin
							if (reading)
								byte_read = shift_reg;
							bit_pos = '0;
							phase_now = BUS_IDLE;
							r.done = 1'b1;
						end else begin
							bit_pos++;
							if (reading)
								phase_now = RD_LOW;
							else
								phase_now = WR_LOW;
						end
					end
					default: phase_now = BUS_IDLE;
				endcase
			end
		end
		if (phase_now == RST_LOW || phase_now == WR_LOW || phase_now == RD_LOW)
			r.drive = 1'b1;
		else if (phase_now == WR_HOLD)
			r.drive = ~shift_reg[bit_pos];
		r.busy = (phase_now != BUS_IDLE);
		r.presence = presence_seen;
		r.rdata = byte_read;
		status_queue.push_back(r);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic pick_level(int mode);
		if (mode == LVL_LOW)
			return 1'b0;
		if (mode == LVL_HIGH)
			return 1'b1;
		return 1'($urandom);
	endfunction

	function automatic logic [15:0] pick_timing();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'd0;
		if (r < 80)
			return 16'($urandom_range(1, 4));
		return 16'($urandom_range(5, 12));
	endfunction

	function automatic logic [1:0] pick_req();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return owbm_pkg::REQ_RESET;
		if (r < 60)
			return owbm_pkg::REQ_WRITE;
		if (r < 95)
			return owbm_pkg::REQ_READ;
		return owbm_pkg::REQ_TICK;
	endfunction

	task automatic queue_tick(input logic [1:0] req, input logic [7:0] wdata,
			input logic level);
		bus_tick_t t;
		t.req = req;
		t.wdata = wdata;
		t.level = level;
		tick_queue.push_back(t);
		queued++;
	endtask

	// start tick plus every tick up to and including the done tick
	task automatic queue_command(input logic [1:0] req, input logic [7:0] wdata,
			input int level_mode, input int noise_pct);
		int         fill;
		logic [1:0] fill_req;
		fill = command_ticks(req);
		queue_tick(req, wdata, pick_level(level_mode));
		repeat (fill) begin
			fill_req = owbm_pkg::REQ_TICK;
			if ($urandom_range(0, 99) < noise_pct)
				fill_req = 2'($urandom_range(1, 3));
			queue_tick(fill_req, 8'($urandom), pick_level(level_mode));
		end
	endtask

	// wait until every beat has gone through and the sequencer is back at rest
	task automatic settle();
		bit at_rest;
		at_rest = 1'b0;
		while (!at_rest) begin
			while (tick_queue.size() != 0 || holding || status_queue.size() != 0)
				@(posedge clk);
			if (phase_now == BUS_IDLE)
				at_rest = 1'b1;
			else
				repeat (16) queue_tick(owbm_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic load_timing(input logic [owbm_pkg::CFG_W-1:0] vals [owbm_pkg::CFG_NUM]);
		@(posedge clk);
		for (int i = 0; i < owbm_pkg::CFG_NUM; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= owbm_pkg::CFG_IDX_W'(i);
			cfg_data <= vals[i];
			timing[i] = vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		errors++;
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	task automatic check_status(input logic [owbm_pkg::OUT_TDATA_W-1:0] beat);
		bus_status_t want;
		if (status_queue.size() == 0) begin
			flag_mismatch("unexpected result beat", 16'(beat), 16'd0);
			return;
		end
		want = status_queue.pop_front();
		if (beat[owbm_pkg::OUT_DRIVE] !== want.drive)
			flag_mismatch("drive_low", 16'(beat[owbm_pkg::OUT_DRIVE]), 16'(want.drive));
		if (beat[owbm_pkg::OUT_BUSY] !== want.busy)
			flag_mismatch("busy", 16'(beat[owbm_pkg::OUT_BUSY]), 16'(want.busy));
		if (beat[owbm_pkg::OUT_DONE] !== want.done)
			flag_mismatch("done", 16'(beat[owbm_pkg::OUT_DONE]), 16'(want.done));
		if (beat[owbm_pkg::OUT_PRESENCE] !== want.presence)
			flag_mismatch("presence", 16'(beat[owbm_pkg::OUT_PRESENCE]),
				16'(want.presence));
		if (beat[owbm_pkg::OUT_RDATA_LO +: 8] !== want.rdata)
			flag_mismatch("read_data", 16'(beat[owbm_pkg::OUT_RDATA_LO +: 8]),
				16'(want.rdata));
		if (beat[owbm_pkg::OUT_REJECTED] !== want.rejected)
			flag_mismatch("rejected", 16'(beat[owbm_pkg::OUT_REJECTED]),
				16'(want.rejected));
	endtask

	// input side: one tick per beat, random gaps between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			holding = 1'b0;
			gap_left = 0;
		end else begin
			if (holding && s_tvalid && s_tready) begin
				step_bus(held_tick);
				holding = 1'b0;
			end
			if (!holding) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (tick_queue.size() != 0) begin
					held_tick = tick_queue.pop_front();
					holding = 1'b1;
					gap_left = steady_in ? 0 : pick_gap();
				end
			end
			s_tvalid <= holding;
			s_tdata <= {5'b0, held_tick.level, held_tick.wdata, held_tick.req};
		end
	end

	// output side: check each beat, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_status(m_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = steady_out ? 0 : pick_gap();
				m_tready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [owbm_pkg::CFG_W-1:0] vals [owbm_pkg::CFG_NUM];
		int                         target;
		int                         r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// byte slots with the timings as they come out of reset
		queue_command(owbm_pkg::REQ_WRITE, 8'($urandom), LVL_RANDOM, 2);
		queue_command(owbm_pkg::REQ_READ, 8'($urandom), LVL_RANDOM, 2);
		settle();

		// every register zero, so every phase lasts one tick
		vals = '{default: 16'd0};
		load_timing(vals);
		queue_tick(owbm_pkg::REQ_TICK, 8'hFF, 1'b1);
		queue_command(owbm_pkg::REQ_RESET, 8'h00, LVL_LOW, 0);
		queue_command(owbm_pkg::REQ_RESET, 8'hFF, LVL_HIGH, 0);
		queue_command(owbm_pkg::REQ_WRITE, 8'h00, LVL_RANDOM, 0);
		queue_command(owbm_pkg::REQ_WRITE, 8'hFF, LVL_RANDOM, 0);
		queue_command(owbm_pkg::REQ_READ, 8'h00, LVL_HIGH, 0);
		queue_command(owbm_pkg::REQ_READ, 8'hFF, LVL_LOW, 0);
		queue_command(owbm_pkg::REQ_READ, 8'hA5, LVL_RANDOM, 0);
		// start requests on every busy tick, the done tick included
		queue_command(owbm_pkg::REQ_WRITE, 8'h5A, LVL_RANDOM, 100);
		queue_command(owbm_pkg::REQ_READ, 8'h3C, LVL_RANDOM, 100);
		queue_tick(owbm_pkg::REQ_TICK, 8'h00, 1'b0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < owbm_pkg::CFG_NUM; i++)
				vals[i] = pick_timing();
			load_timing(vals);
			steady_in = ($urandom_range(0, 3) == 0);
			steady_out = ($urandom_range(0, 3) == 0);
			target = queued + PHASE_TICKS;
			while (queued < target) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					queue_command(pick_req(), 8'($urandom), LVL_RANDOM,
						($urandom_range(0, 99) < 30) ? 20 : 0);
					repeat ($urandom_range(0, 2))
						queue_tick(owbm_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
				end else if (r < 90) begin
					queue_tick(owbm_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
				end else begin
					// stray request, may start a command out of step
					queue_tick(2'($urandom), 8'($urandom), 1'($urandom));
				end
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
